[hdl/imh_pkg.sv]
// Package for the indexed min-heap: status codes, FSM states, command/status structs.
// No dependencies.
`default_nettype none
package imh_pkg;
    localparam int HEAP_CAPACITY_DEF = 1024;
    localparam int KEY_SPACE_DEF     = 1024;
    localparam int PRIORITY_BITS_DEF = 32;

    localparam int KEY_W    = 10;
    localparam int PRIO_W   = 32;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 11;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_PRESENT  = 3'd1,
        ST_FULL     = 3'd2,
        ST_POPPED   = 3'd3,
        ST_EMPTY    = 3'd4
    } status_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_DECIDE,
        S_UP_RD,
        S_UP_WAIT,
        S_UP_CMP,
        S_POP_RD,
        S_POP_MOVE,
        S_DN_RD,
        S_DN_WAIT,
        S_DN_CMP,
        S_DN_WR,
        S_POP_FIX,
        S_ROOT_RD,
        S_ROOT_WAIT,
        S_DONE
    } state_t;

    typedef enum logic [3:0] {
        C_NONE,
        C_CLEAR,
        C_LATCH,
        C_LOOKUP,
        C_DECIDE,
        C_UP_RD,
        C_UP_CMP,
        C_POP_RD,
        C_POP_MOVE,
        C_DN_RD,
        C_DN_CMP,
        C_DN_WR,
        C_POP_FIX,
        C_ROOT_RD,
        C_RESULT
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t op;
    } imh_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic is_pop;
        logic present;
        logic full;
        logic empty;
        logic up_done;
        logic up_swap;
        logic dn_swap;
    } imh_stat_t;
endpackage
`default_nettype wire

[hdl/imh_datapath.sv]
// Datapath for the indexed min-heap: slot memories, position map, sift registers.
// Depends on imh_pkg; driven by imh_ctrl commands.
`default_nettype none
module imh_datapath
    import imh_pkg::*;
#(
    parameter int HEAP_CAPACITY = HEAP_CAPACITY_DEF,
    parameter int KEY_SPACE     = KEY_SPACE_DEF,
    parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire imh_cmd_t            cmd,
    output imh_stat_t                stat,
    input  wire logic                action,
    input  wire logic [KEY_W-1:0]    key,
    input  wire logic [PRIO_W-1:0]   priority_req,
    output logic [STATUS_W-1:0]      r_status,
    output logic [KEY_W-1:0]         r_popped_key,
    output logic [PRIO_W-1:0]        r_popped_priority,
    output logic [KEY_W-1:0]         r_min_key,
    output logic [PRIO_W-1:0]        r_min_priority,
    output logic [COUNT_W-1:0]       r_entry_count
);
    localparam int SA_W = (HEAP_CAPACITY > 1) ? $clog2(HEAP_CAPACITY) : 1;
    localparam int KA_W = (KEY_SPACE > 1) ? $clog2(KEY_SPACE) : 1;
    localparam int CN_W = $clog2(HEAP_CAPACITY + 1);
    localparam int IK_W = (KA_W + 1 > KEY_W) ? KA_W + 1 : KEY_W;  // holds KEY_SPACE itself
    localparam int PS_W = SA_W + 1;  // slot+1, zero = absent
    localparam int IX_W = SA_W + 2;  // child index headroom

    // slot memory: {key, priority}
    logic [KA_W+PRIORITY_BITS-1:0] slot_mem [HEAP_CAPACITY];
    logic [PS_W-1:0]               pos_mem  [KEY_SPACE];

    logic [KA_W+PRIORITY_BITS-1:0] s_rd_a_reg, s_rd_b_reg;
    logic [PS_W-1:0]               p_rd_reg;

    logic                     is_pop_reg;
    logic [KA_W-1:0]          in_key_reg;
    logic [PRIORITY_BITS-1:0] in_prio_reg;
    logic [CN_W-1:0]          count_reg, count_next;
    logic [SA_W-1:0]          pos_reg, pos_next;
    logic [KA_W-1:0]          cur_key_reg;
    logic [PRIORITY_BITS-1:0] cur_prio_reg;
    logic [KA_W-1:0]          pk_reg;
    logic [PRIORITY_BITS-1:0] pp_reg;
    logic [STATUS_W-1:0]      status_reg;
    logic                     present_reg, lower_reg;
    logic [KA_W-1:0]          clr_reg;
    logic                     clr_done_reg;
    logic [SA_W-1:0]          best_reg;
    logic                     best_sw_reg;

    // memory port controls
    logic                          s_re;
    logic                          s_we_a;
    logic [SA_W-1:0]               s_wa_a, s_ra_a, s_ra_b;
    logic [KA_W+PRIORITY_BITS-1:0] s_wd_a;
    logic                          p_we;
    logic [KA_W-1:0]               p_wa, p_ra;
    logic [PS_W-1:0]               p_wd;

    logic [IK_W-1:0]  key_ext;
    logic [KA_W-1:0]  key_mod;
    logic [SA_W-1:0]  parent;
    logic [IX_W-1:0]  left_ix, right_ix;
    logic             has_left, has_right;
    logic [PRIORITY_BITS-1:0] pa_prio, pb_prio;
    logic [KA_W-1:0]  pa_key, pb_key;
    logic             right_better;
    logic [PRIORITY_BITS-1:0] best_prio;
    logic [PRIORITY_BITS-1:0] cmp_prio;

    assign key_ext = IK_W'(key);
    assign key_mod = KA_W'(key_ext % IK_W'(KEY_SPACE));
    assign parent  = SA_W'((pos_reg - SA_W'(1)) >> 1);
    assign left_ix  = (IX_W'(pos_reg) << 1) + IX_W'(1);
    assign right_ix = left_ix + IX_W'(1);
    assign has_left  = left_ix  < IX_W'(count_reg);
    assign has_right = right_ix < IX_W'(count_reg);
    assign pa_prio = s_rd_a_reg[PRIORITY_BITS-1:0];
    assign pb_prio = s_rd_b_reg[PRIORITY_BITS-1:0];
    assign pa_key  = s_rd_a_reg[KA_W+PRIORITY_BITS-1:PRIORITY_BITS];
    assign pb_key  = s_rd_b_reg[KA_W+PRIORITY_BITS-1:PRIORITY_BITS];
    assign right_better = has_right && (pb_prio < pa_prio);
    assign best_prio = right_better ? pb_prio : pa_prio;
    // present key, first compare: keep the lower of the stored and requested priority
    assign cmp_prio = !lower_reg ? cur_prio_reg :
                      (in_prio_reg < pb_prio) ? in_prio_reg : pb_prio;

    always_ff @(posedge clk)
    begin
        if (s_we_a)
            slot_mem[s_wa_a] <= s_wd_a;
        if (s_re)
        begin
            s_rd_a_reg <= slot_mem[s_ra_a];
            s_rd_b_reg <= slot_mem[s_ra_b];
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_we)
            pos_mem[p_wa] <= p_wd;
        p_rd_reg <= pos_mem[p_ra];
    end

    always_comb
    begin
        s_re = 1'b0;
        s_we_a = 1'b0;
        s_wa_a = pos_reg;
        s_wd_a = {cur_key_reg, cmp_prio};
        s_ra_a = pos_reg; s_ra_b = pos_reg;
        p_we = 1'b0; p_wa = cur_key_reg; p_ra = in_key_reg;
        p_wd = PS_W'(pos_reg) + PS_W'(1);
        count_next = count_reg;
        pos_next = pos_reg;
        unique case (cmd.op)
            C_CLEAR:
            begin
                p_we = 1'b1; p_wa = clr_reg; p_wd = '0;
            end
            C_DECIDE:
            begin
                if (!is_pop_reg && present_reg)
                    pos_next = SA_W'(p_rd_reg - PS_W'(1));
                else if (!is_pop_reg)
                    pos_next = SA_W'(count_reg);
            end
            C_UP_RD:
            begin
                s_re = 1'b1;
                s_ra_a = parent;
            end
            C_UP_CMP:
            begin
                // parent greater: parent moves down into pos
                if (pos_reg != '0 && pa_prio > cmp_prio)
                begin
                    s_we_a = 1'b1; s_wa_a = pos_reg; s_wd_a = s_rd_a_reg;
                    p_we = 1'b1; p_wa = pa_key; p_wd = PS_W'(pos_reg) + PS_W'(1);
                    pos_next = parent;
                end
                else
                begin
                    s_we_a = 1'b1;
                    p_we = 1'b1;
                end
            end
            C_POP_RD:
            begin
                s_re = 1'b1;
                s_ra_a = '0;
                s_ra_b = SA_W'(count_reg - CN_W'(1));
            end
            C_POP_MOVE:
            begin
                count_next = count_reg - CN_W'(1);
                pos_next = '0;
            end
            C_DN_RD:
            begin
                s_re = 1'b1;
                s_ra_a = SA_W'(left_ix);
                s_ra_b = SA_W'(right_ix);
            end
            C_DN_CMP:
            begin
            end
            C_DN_WR:
            begin
                if (best_sw_reg)
                begin
                    s_we_a = 1'b1; s_wa_a = pos_reg;
                    s_wd_a = best_reg == SA_W'(left_ix) ? s_rd_a_reg : s_rd_b_reg;
                    p_we = 1'b1;
                    p_wa = best_reg == SA_W'(left_ix) ? pa_key : pb_key;
                    pos_next = best_reg;
                end
                else
                begin
                    s_we_a = 1'b1;
                    p_we = 1'b1;
                end
            end
            C_POP_FIX:
            begin
                p_we = 1'b1; p_wa = pk_reg; p_wd = '0;
            end
            C_ROOT_RD:
            begin
                s_re = 1'b1;
                s_ra_a = '0;
            end
            default:
            begin
            end
        endcase
        if (cmd.op == C_DECIDE && !is_pop_reg && !present_reg && !stat.full)
            count_next = count_reg + CN_W'(1);
        if (cmd.op == C_DN_WR && best_sw_reg)
            p_wd = PS_W'(pos_reg) + PS_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            clr_reg      <= '0;
            clr_done_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.op == C_CLEAR)
            begin
                clr_reg <= clr_reg + KA_W'(1);
                if (clr_reg == KA_W'(KEY_SPACE - 1))
                    clr_done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        unique case (cmd.op)
            C_LATCH:
            begin
                is_pop_reg  <= action;
                in_key_reg  <= key_mod;
                in_prio_reg <= PRIORITY_BITS'(priority_req);
            end
            C_DECIDE:
            begin
                cur_key_reg  <= in_key_reg;
                lower_reg    <= !is_pop_reg && present_reg;
                if (is_pop_reg)
                    status_reg <= count_reg == '0 ? ST_EMPTY : ST_POPPED;
                else if (present_reg)
                    status_reg <= ST_PRESENT;
                else if (stat.full)
                    status_reg <= ST_FULL;
                else
                begin
                    status_reg   <= ST_INSERTED;
                    cur_prio_reg <= in_prio_reg;
                end
            end
            C_LOOKUP:
            begin
                present_reg <= 1'b0;
            end
            C_UP_CMP:
            begin
                cur_prio_reg <= cmp_prio;
                lower_reg    <= 1'b0;
            end
            C_POP_MOVE:
            begin
                pk_reg       <= pa_key;
                pp_reg       <= pa_prio;
                cur_key_reg  <= pb_key;
                cur_prio_reg <= pb_prio;
            end
            C_DN_CMP:
            begin
                best_reg    <= right_better ? SA_W'(right_ix) : SA_W'(left_ix);
                best_sw_reg <= has_left && (best_prio < cur_prio_reg);
            end
            default:
            begin
            end
        endcase
        // map read lands in the cycle after C_LOOKUP
        if (cmd.op == C_NONE && p_rd_reg != '0 && PS_W'(p_rd_reg) <= PS_W'(count_reg))
            present_reg <= 1'b1;
        if (cmd.op == C_RESULT)
        begin
            r_status          <= status_reg;
            r_popped_key      <= status_reg == ST_POPPED ? KEY_W'(pk_reg) : '0;
            r_popped_priority <= status_reg == ST_POPPED ? PRIO_W'(pp_reg) : '0;
            r_min_key         <= count_reg != '0 ? KEY_W'(pa_key) : '0;
            r_min_priority    <= count_reg != '0 ? PRIO_W'(pa_prio) : '0;
            r_entry_count     <= COUNT_W'(count_reg);
        end
    end

    assign stat.clear_done = clr_done_reg;
    assign stat.is_pop     = is_pop_reg;
    assign stat.present    = present_reg;
    assign stat.full       = count_reg >= CN_W'(HEAP_CAPACITY);
    assign stat.empty      = count_reg == '0;
    assign stat.up_done    = pos_reg == '0;
    assign stat.up_swap    = pa_prio > cmp_prio;
    assign stat.dn_swap    = best_sw_reg;
endmodule
`default_nettype wire

[hdl/imh_ctrl.sv]
// Controller FSM for the indexed min-heap; sequences clear, lookup, sift up/down.
// Depends on imh_pkg.
`default_nettype none
module imh_ctrl
    import imh_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  wire logic      out_stall,
    output imh_cmd_t       cmd,
    input  wire imh_stat_t stat
);
    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   pres_chk_reg, pres_chk_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
            pres_chk_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pres_chk_reg  <= pres_chk_next;
        end
    end

    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        pres_chk_next  = pres_chk_reg;
        cmd.op         = C_NONE;
        in_stall       = 1'b1;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.op = C_CLEAR;
                if (stat.clear_done)
                begin
                    cmd.op = C_NONE;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.op = C_LATCH;
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                cmd.op = C_LOOKUP;
                state_next = S_DECIDE;
                pres_chk_next = 1'b1;
            end
            S_DECIDE:
            begin
                // while pres_chk is set: map read lands (C_NONE sets present); once it clears: decide
                if (pres_chk_reg)
                begin
                    pres_chk_next = 1'b0;
                end
                else
                begin
                    cmd.op = C_DECIDE;
                    if (stat.is_pop)
                        state_next = stat.empty ? S_ROOT_RD : S_POP_RD;
                    else if (stat.present)
                        state_next = S_UP_RD;
                    else if (stat.full)
                        state_next = S_ROOT_RD;
                    else
                        state_next = S_UP_RD;
                end
            end
            S_UP_RD:
            begin
                cmd.op = C_UP_RD;
                state_next = S_UP_WAIT;
            end
            S_UP_WAIT:
            begin
                state_next = S_UP_CMP;
            end
            S_UP_CMP:
            begin
                cmd.op = C_UP_CMP;
                if (!stat.up_done && stat.up_swap)
                    state_next = S_UP_RD;
                else
                    state_next = S_ROOT_RD;
            end
            S_POP_RD:
            begin
                cmd.op = C_POP_RD;
                state_next = S_POP_MOVE;
            end
            S_POP_MOVE:
            begin
                cmd.op = C_POP_MOVE;
                state_next = S_DN_RD;
            end
            S_DN_RD:
            begin
                cmd.op = C_DN_RD;
                state_next = S_DN_WAIT;
            end
            S_DN_WAIT:
            begin
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                cmd.op = C_DN_CMP;
                state_next = S_DN_WR;
            end
            S_DN_WR:
            begin
                cmd.op = C_DN_WR;
                state_next = stat.dn_swap ? S_DN_RD : S_POP_FIX;
            end
            S_POP_FIX:
            begin
                cmd.op = C_POP_FIX;
                state_next = S_ROOT_RD;
            end
            S_ROOT_RD:
            begin
                cmd.op = C_ROOT_RD;
                state_next = S_ROOT_WAIT;
            end
            S_ROOT_WAIT:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.op = C_RESULT;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

[hdl/indexed_min_heap_decrease_key_top.sv]
// Indexed min-heap with decrease-key, one beat in flight. Each beat looks up the key
// map, then a push sifts up and a pop sifts down level by level, with no sift for a
// dropped push or an empty pop; the root is then read for the result. Next beat is
// taken once the controller returns to idle after the result loads; a result not yet
// taken holds the controller. After reset the key map is swept clear, one key per
// cycle, before the first beat is taken.
`default_nettype none
module indexed_min_heap_decrease_key_top
    import imh_pkg::*;
#(
    parameter int HEAP_CAPACITY = HEAP_CAPACITY_DEF,
    parameter int KEY_SPACE     = KEY_SPACE_DEF,
    parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic                action,
    input  wire logic [KEY_W-1:0]    key,
    input  wire logic [PRIO_W-1:0]   priority_req,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [STATUS_W-1:0]      status,
    output logic [KEY_W-1:0]         popped_key,
    output logic [PRIO_W-1:0]        popped_priority,
    output logic [KEY_W-1:0]         min_key,
    output logic [PRIO_W-1:0]        min_priority,
    output logic [COUNT_W-1:0]       entry_count
);
    imh_cmd_t  cmd;
    imh_stat_t stat;

    imh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    imh_datapath #(
        .HEAP_CAPACITY (HEAP_CAPACITY),
        .KEY_SPACE     (KEY_SPACE),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .action            (action),
        .key               (key),
        .priority_req      (priority_req),
        .r_status          (status),
        .r_popped_key      (popped_key),
        .r_popped_priority (popped_priority),
        .r_min_key         (min_key),
        .r_min_priority    (min_priority),
        .r_entry_count     (entry_count)
    );

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> entry_count <= COUNT_W'(HEAP_CAPACITY))
        else $error("entry count above capacity");
    a_empty_min: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && entry_count == '0 |-> min_key == '0 && min_priority == '0)
        else $error("empty heap reports a minimum");
    a_pop_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_POPPED |-> popped_key == '0 && popped_priority == '0)
        else $error("pop fields set on non-pop");
endmodule
`default_nettype wire
